FILE: hw/rtl/uart_16550_register_model_assert.svh
// Assertion macros for the UART register block.
// Included by the top level; the checks use its i_clk and i_rst_n.
`ifndef UART_16550_REGISTER_MODEL_ASSERT_SVH
`define UART_16550_REGISTER_MODEL_ASSERT_SVH

// A condition that must never hold while out of reset.
`define URM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define URM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/urm_pkg.sv
// Shared types, codes and helper functions for the UART register block.
// Used by urm_rx_mem and uart_16550_register_model; depends on nothing.
package urm_pkg;

    // Default sizes.
    localparam int DEF_FIFO_DEPTH       = 16;
    localparam int DEF_RX_TIMEOUT_TICKS = 1024;

    // Request kinds.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Register offsets.
    localparam logic [2:0] ADDR_RBR = 3'd0;
    localparam logic [2:0] ADDR_IER = 3'd1;
    localparam logic [2:0] ADDR_IIR = 3'd2;
    localparam logic [2:0] ADDR_LCR = 3'd3;
    localparam logic [2:0] ADDR_MCR = 3'd4;
    localparam logic [2:0] ADDR_LSR = 3'd5;
    localparam logic [2:0] ADDR_MSR = 3'd6;
    localparam logic [2:0] ADDR_SPR = 3'd7;

    // Interrupt identification codes.
    localparam logic [3:0] IIR_NONE = 4'h1;
    localparam logic [3:0] IIR_LINE = 4'h6;
    localparam logic [3:0] IIR_RX   = 4'h4;
    localparam logic [3:0] IIR_TMO  = 4'hC;
    localparam logic [3:0] IIR_THR  = 4'h2;

    // Pending interrupt bit positions.
    localparam int PEND_LINE = 0;
    localparam int PEND_RX   = 1;
    localparam int PEND_TMO  = 2;
    localparam int PEND_THR  = 3;

    // Register masks.
    localparam logic [7:0] FCR_KEEP_MASK  = 8'hC9;
    localparam logic [7:0] LSR_READ_CLEAR = 8'h9E;
    localparam logic [7:0] MSR_STATE_MASK = 8'hF0;
    localparam logic [7:0] LSR_RESET      = 8'h60;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] addr;
        logic [7:0] wdata;
    } t_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       tx_valid;
        logic [7:0] tx_data;
    } t_rsp;

    // Write strobe and data toward the receive buffer memory.
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_rx_wr;

    // Receive trigger level from the FIFO control register.
    function automatic logic [3:0] trig_level(input logic [7:0] fcr);
        logic [3:0] lvl;
        if (!fcr[0]) begin
            lvl = 4'd1;
        end else begin
            case (fcr[7:6])
                2'd0:    lvl = 4'd1;
                2'd1:    lvl = 4'd4;
                2'd2:    lvl = 4'd8;
                default: lvl = 4'd14;
            endcase
        end
        return lvl;
    endfunction

    // Highest-priority enabled interrupt, gated by OUT2.
    function automatic logic [3:0] iir_code(input logic [4:0] mcr,
                                            input logic [3:0] pend,
                                            input logic [3:0] ier);
        logic [3:0] code;
        if (!mcr[3])                          code = IIR_NONE;
        else if (pend[PEND_LINE] && ier[2])   code = IIR_LINE;
        else if (pend[PEND_RX] && ier[0])     code = IIR_RX;
        else if (pend[PEND_TMO] && ier[0])    code = IIR_TMO;
        else if (pend[PEND_THR] && ier[1])    code = IIR_THR;
        else                                  code = IIR_NONE;
        return code;
    endfunction

endpackage

FILE: hw/rtl/urm_rx_mem.sv
// Receive buffer storage for the UART register block.
// Depends on urm_pkg for the write transaction type.
module urm_rx_mem #(
    parameter int FIFO_DEPTH = urm_pkg::DEF_FIFO_DEPTH,
    localparam int IDX_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  urm_pkg::t_rx_wr       i_wr,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output logic [7:0]            o_rd_data
);

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_idx] <= i_wr.data;
        end
    end

    // Registered read of the next head entry, with bypass of a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == i_rd_idx)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/uart_16550_register_model.sv
// Top level of the 16550-style UART register block.
// Depends on urm_pkg, urm_rx_mem and uart_16550_register_model_assert.svh.
//
//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+----------------------
//  request | in        | i_valid / o_stall             | i_req (t_req)
//  result  | out       | o_valid / i_stall             | o_rsp (t_rsp)
//
// One transaction is accepted per cycle while o_stall is low; its result is offered
// once the input register and then the result register hold it.
// All register updates happen in one pass between those two registers.
// A stalled result holds the pipeline; the input register keeps one more
// transaction, and o_stall rises only when both registers are occupied.
// Reset is synchronous; the receive buffer needs no clearing pass.
module uart_16550_register_model #(
    parameter int FIFO_DEPTH       = urm_pkg::DEF_FIFO_DEPTH,
    parameter int RX_TIMEOUT_TICKS = urm_pkg::DEF_RX_TIMEOUT_TICKS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  urm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output urm_pkg::t_rsp o_rsp
);

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int TMO_W = (RX_TIMEOUT_TICKS > 1) ? $clog2(RX_TIMEOUT_TICKS + 1) : 1;

    // Pipeline registers.
    logic          r_in_vld;
    urm_pkg::t_req r_in;
    logic          r_out_vld;
    urm_pkg::t_rsp r_out;
    urm_pkg::t_rsp n_out;

    // Architectural state.
    logic [IDX_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_last,  n_last;
    logic [3:0]       r_ier,   n_ier;
    logic [7:0]       r_fcr,   n_fcr;
    logic [7:0]       r_lcr,   n_lcr;
    logic [4:0]       r_mcr,   n_mcr;
    logic [7:0]       r_lsr,   n_lsr;
    logic [7:0]       r_msr,   n_msr;
    logic [7:0]       r_spr,   n_spr;
    logic [7:0]       r_dll,   n_dll;
    logic [7:0]       r_dlm,   n_dlm;
    logic [3:0]       r_pend,  n_pend;
    logic [TMO_W-1:0] r_tmo,   n_tmo;

    // Working signals.
    logic             adv;
    logic             upd;
    logic             dlab;
    logic             fifo_en;
    logic [3:0]       trig;
    logic [3:0]       code;
    logic             push;
    logic [7:0]       push_data;
    logic             over;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       head_data;
    logic [7:0]       nm;
    logic [7:0]       chg;
    logic             fcr_changed;
    urm_pkg::t_rx_wr  rx_wr;
    logic             chk_dr_bad;
    logic             chk_count_bad;
    logic             chk_tmo_bad;

    // Handshake: the pass advances when the result register is free or drains.
    assign adv     = !r_out_vld || !i_stall;
    assign upd     = r_in_vld && adv;
    assign o_stall = r_in_vld && !adv;
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    // Current-state decodes.
    assign dlab    = r_lcr[7];
    assign fifo_en = r_fcr[0];
    assign trig    = urm_pkg::trig_level(r_fcr);
    assign code    = urm_pkg::iir_code(r_mcr, r_pend, r_ier);

    // Tail slot for a push, wrapping once past the end of the buffer.
    always_comb begin
        tail_sum = (IDX_W + 1)'(r_head) + (IDX_W + 1)'(r_count);
        if (tail_sum >= (IDX_W + 1)'(FIFO_DEPTH)) begin
            tail_sum = tail_sum - (IDX_W + 1)'(FIFO_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
    end

    // Loopback modem status from the MCR value being written:
    // OUT2->DCD, OUT1->RI, DTR->DSR, RTS->CTS.
    always_comb begin
        nm  = {r_in.wdata[3], r_in.wdata[2], r_in.wdata[0], r_in.wdata[1], 4'b0000};
        chg = (r_msr ^ nm) & urm_pkg::MSR_STATE_MASK;
    end

    assign fcr_changed = r_fcr[0] ^ r_in.wdata[0];

    // Next-state and result logic for the transaction in the input register.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_last    = r_last;
        n_ier     = r_ier;
        n_fcr     = r_fcr;
        n_lcr     = r_lcr;
        n_mcr     = r_mcr;
        n_lsr     = r_lsr;
        n_msr     = r_msr;
        n_spr     = r_spr;
        n_dll     = r_dll;
        n_dlm     = r_dlm;
        n_pend    = r_pend;
        n_tmo     = r_tmo;
        n_out     = '0;
        push      = 1'b0;
        push_data = r_in.wdata;
        over      = 1'b0;
        rx_wr     = '0;

        case (r_in.req_type)
            urm_pkg::REQ_READ: begin
                unique case (r_in.addr)
                    urm_pkg::ADDR_RBR: begin
                        if (dlab) begin
                            n_out.rdata = r_dll;
                        end else begin
                            if (r_count != '0) begin
                                n_last  = head_data;
                                n_head  = (r_head == IDX_W'(FIFO_DEPTH - 1)) ?
                                          '0 : r_head + 1'b1;
                                n_count = r_count - 1'b1;
                                if (n_count == '0) begin
                                    n_lsr[0] = 1'b0;
                                end
                                if (32'(n_count) < 32'(trig)) begin
                                    n_pend[urm_pkg::PEND_RX] = 1'b0;
                                end
                                n_tmo = '0;
                                n_pend[urm_pkg::PEND_TMO] = 1'b0;
                            end
                            n_out.rdata = n_last;
                        end
                    end
                    urm_pkg::ADDR_IER: begin
                        n_out.rdata = dlab ? r_dlm : {4'b0000, r_ier};
                    end
                    urm_pkg::ADDR_IIR: begin
                        n_out.rdata = {fifo_en ? 2'b11 : 2'b00, 2'b00, code};
                        if (code == urm_pkg::IIR_THR) begin
                            n_pend[urm_pkg::PEND_THR] = 1'b0;
                        end
                    end
                    urm_pkg::ADDR_LCR: n_out.rdata = r_lcr;
                    urm_pkg::ADDR_MCR: n_out.rdata = {3'b000, r_mcr};
                    urm_pkg::ADDR_LSR: begin
                        n_out.rdata = r_lsr;
                        n_lsr       = r_lsr & ~urm_pkg::LSR_READ_CLEAR;
                        n_pend[urm_pkg::PEND_LINE] = 1'b0;
                    end
                    urm_pkg::ADDR_MSR: begin
                        n_out.rdata = r_msr;
                        n_msr       = r_msr & urm_pkg::MSR_STATE_MASK;
                    end
                    default: n_out.rdata = r_spr;
                endcase
            end
            urm_pkg::REQ_WRITE: begin
                unique case (r_in.addr)
                    urm_pkg::ADDR_RBR: begin
                        if (dlab) begin
                            n_dll = r_in.wdata;
                        end else begin
                            if (r_mcr[4]) begin
                                push = 1'b1;
                            end else begin
                                n_out.tx_valid = 1'b1;
                                n_out.tx_data  = r_in.wdata;
                            end
                            n_pend[urm_pkg::PEND_THR] = 1'b1;
                        end
                    end
                    urm_pkg::ADDR_IER: begin
                        if (dlab) begin
                            n_dlm = r_in.wdata;
                        end else begin
                            n_ier = r_in.wdata[3:0];
                            if (n_ier[0] && r_lsr[0]) begin
                                n_pend[urm_pkg::PEND_RX] = 1'b1;
                            end
                            if (!r_ier[1] && n_ier[1] && r_lsr[5]) begin
                                n_pend[urm_pkg::PEND_THR] = 1'b1;
                            end
                        end
                    end
                    urm_pkg::ADDR_IIR: begin
                        n_fcr = r_in.wdata & urm_pkg::FCR_KEEP_MASK;
                        if (r_in.wdata[1] || fcr_changed || !n_fcr[0]) begin
                            n_head   = '0;
                            n_count  = '0;
                            n_lsr[0] = 1'b0;
                            n_pend[urm_pkg::PEND_RX]  = 1'b0;
                            n_pend[urm_pkg::PEND_TMO] = 1'b0;
                            n_tmo    = '0;
                        end
                        if (r_in.wdata[2] || fcr_changed) begin
                            n_pend[urm_pkg::PEND_THR] = 1'b1;
                        end
                    end
                    urm_pkg::ADDR_LCR: n_lcr = r_in.wdata;
                    urm_pkg::ADDR_MCR: begin
                        n_mcr = r_in.wdata[4:0];
                        if (n_mcr[4]) begin
                            n_msr = nm | {4'b0000, chg[7],
                                          r_msr[6] && !nm[6], chg[5], chg[4]};
                        end else if (r_mcr[4]) begin
                            n_msr = '0;
                        end
                    end
                    urm_pkg::ADDR_SPR: n_spr = r_in.wdata;
                    default: ;
                endcase
            end
            urm_pkg::REQ_RX: begin
                push = 1'b1;
            end
            default: begin
                // Character timeout counts only while FIFO mode holds data.
                if (fifo_en && (r_count != '0) &&
                    (32'(r_tmo) < 32'(RX_TIMEOUT_TICKS))) begin
                    n_tmo = r_tmo + 1'b1;
                    if (32'(n_tmo) >= 32'(RX_TIMEOUT_TICKS)) begin
                        n_pend[urm_pkg::PEND_TMO] = 1'b1;
                    end
                end
            end
        endcase

        // Receive push: a full buffer drops the byte and flags overrun.
        if (push) begin
            over = fifo_en ? (32'(r_count) >= 32'(FIFO_DEPTH)) : (r_count != '0);
            if (!over) begin
                rx_wr.en   = upd;
                rx_wr.data = push_data;
                n_count    = r_count + 1'b1;
            end
            n_lsr[0] = 1'b1;
            if (over) begin
                n_lsr[1] = 1'b1;
                n_pend[urm_pkg::PEND_LINE] = 1'b1;
            end
            if (32'(n_count) >= 32'(trig)) begin
                n_pend[urm_pkg::PEND_RX] = 1'b1;
            end
            n_tmo = '0;
            n_pend[urm_pkg::PEND_TMO] = 1'b0;
        end

        n_out.irq = (urm_pkg::iir_code(n_mcr, n_pend, n_ier) != urm_pkg::IIR_NONE);
    end

    // Read address follows the head that the next cycle will see.
    assign rd_idx = upd ? n_head : r_head;

    urm_rx_mem #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_mem (
        .i_clk     (i_clk),
        .i_wr      (rx_wr),
        .i_wr_idx  (tail_idx),
        .i_rd_idx  (rd_idx),
        .o_rd_data (head_data)
    );

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_req;
        end
        if (upd) begin
            r_out <= n_out;
        end
    end

    // Register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_ier   <= '0;
            r_fcr   <= '0;
            r_lcr   <= '0;
            r_mcr   <= '0;
            r_lsr   <= urm_pkg::LSR_RESET;
            r_msr   <= '0;
            r_spr   <= '0;
            r_dll   <= '0;
            r_dlm   <= '0;
            r_pend  <= '0;
            r_tmo   <= '0;
        end else if (upd) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_last  <= n_last;
            r_ier   <= n_ier;
            r_fcr   <= n_fcr;
            r_lcr   <= n_lcr;
            r_mcr   <= n_mcr;
            r_lsr   <= n_lsr;
            r_msr   <= n_msr;
            r_spr   <= n_spr;
            r_dll   <= n_dll;
            r_dlm   <= n_dlm;
            r_pend  <= n_pend;
            r_tmo   <= n_tmo;
        end
    end

    // Conditions watched by the checks below.
    assign chk_dr_bad    = r_lsr[0] != (r_count != '0);
    assign chk_count_bad = (32'(r_count) > 32'(FIFO_DEPTH)) ||
                           (!r_fcr[0] && (r_count > CNT_W'(1)));
    assign chk_tmo_bad   = r_pend[urm_pkg::PEND_TMO] && !r_fcr[0];

    // Checks on the buffer bookkeeping and the pipeline.
    `include "uart_16550_register_model_assert.svh"

    `URM_ASSERT_NEVER(a_data_ready_matches_count, chk_dr_bad, "data ready disagrees with count")
    `URM_ASSERT_NEVER(a_count_in_range, chk_count_bad, "receive count exceeds the depth")
    `URM_ASSERT_NEVER(a_timeout_needs_fifo, chk_tmo_bad, "timeout pending outside FIFO mode")
    `URM_ASSERT_NEXT(a_result_follows_input, upd, r_out_vld, "pass produced no result")

endmodule

FILE: test/uart_16550_register_model_test.sv
// Self-checking testbench for the 16550-style UART register block.
// Drives bus accesses, received bytes and ticks and checks every result
// against a cycle-free behavioral predictor. Depends on urm_pkg and the RTL.
module uart_16550_register_model_test;

    localparam int RXQ_DEPTH    = 16;
    localparam int RXQ_IDX_W    = $clog2(RXQ_DEPTH);
    localparam int TMO_TICKS    = 12;
    localparam int RANDOM_ITEMS = 1100;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_START   = 600;
    localparam int HOLD_LEN     = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 200;

    // Register bit positions.
    localparam int IER_RX        = 0;
    localparam int IER_THR       = 1;
    localparam int IER_LINE      = 2;
    localparam int FCR_FIFO_ON   = 0;
    localparam int FCR_RX_CLEAR  = 1;
    localparam int FCR_TX_CLEAR  = 2;
    localparam int LCR_DIV_LATCH = 7;
    localparam int MCR_DTR       = 0;
    localparam int MCR_RTS       = 1;
    localparam int MCR_AUX1      = 2;
    localparam int MCR_IRQ_GATE  = 3;
    localparam int MCR_LOOP      = 4;
    localparam int LSR_DR        = 0;
    localparam int LSR_OE        = 1;
    localparam int LSR_THRE      = 5;
    localparam int MSR_CTS_DELTA = 0;
    localparam int MSR_DSR_DELTA = 1;
    localparam int MSR_RI_FALL   = 2;
    localparam int MSR_DCD_DELTA = 3;
    localparam int MSR_CTS       = 4;
    localparam int MSR_DSR       = 5;
    localparam int MSR_RI        = 6;
    localparam int MSR_DCD       = 7;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    urm_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    urm_pkg::t_rsp o_rsp;

    uart_16550_register_model #(
        .FIFO_DEPTH       (RXQ_DEPTH),
        .RX_TIMEOUT_TICKS (TMO_TICKS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // Requests waiting to be driven and results the block still owes.
    urm_pkg::t_req req_q[$];
    urm_pkg::t_rsp expected_rsp[$];
    int   total_items;
    int   accepted_count;
    int   result_count;
    int   mismatches;
    int   cycle_count;
    int   gap_left;
    int   stall_left;
    int   holdoff_left;

    // Predicted register state of the UART.
    logic [7:0]  rxq_mem [RXQ_DEPTH];
    int unsigned rxq_head;
    int unsigned rxq_count;
    logic [7:0]  last_rx;
    logic [3:0]  ier;
    logic [7:0]  fcr;
    logic [7:0]  lcr;
    logic [4:0]  mcr;
    logic [7:0]  lsr;
    logic [7:0]  msr;
    logic [7:0]  spr;
    logic [7:0]  dll;
    logic [7:0]  dlm;
    logic [3:0]  pend;
    int unsigned tmo_count;

    function automatic int unsigned rx_trigger_level();
        if (!fcr[FCR_FIFO_ON]) begin
            return 1;
        end
        case (fcr[7:6])
            2'd0:    return 1;
            2'd1:    return 4;
            2'd2:    return 8;
            default: return 14;
        endcase
    endfunction

    // Highest-priority enabled source; the interrupt gate bit masks all of them.
    function automatic logic [3:0] pending_id();
        if (!mcr[MCR_IRQ_GATE])                          return urm_pkg::IIR_NONE;
        if (pend[urm_pkg::PEND_LINE] && ier[IER_LINE])   return urm_pkg::IIR_LINE;
        if (pend[urm_pkg::PEND_RX] && ier[IER_RX])       return urm_pkg::IIR_RX;
        if (pend[urm_pkg::PEND_TMO] && ier[IER_RX])      return urm_pkg::IIR_TMO;
        if (pend[urm_pkg::PEND_THR] && ier[IER_THR])     return urm_pkg::IIR_THR;
        return urm_pkg::IIR_NONE;
    endfunction

    function automatic void rx_flush();
        rxq_head = 0;
        rxq_count = 0;
        lsr[LSR_DR] = 1'b0;
        pend[urm_pkg::PEND_RX] = 1'b0;
        pend[urm_pkg::PEND_TMO] = 1'b0;
        tmo_count = 0;
    endfunction

    // A full queue drops the byte and flags an overrun.
    function automatic void rx_enqueue(input logic [7:0] ch);
        int unsigned cap;
        bit          over;
        cap = fcr[FCR_FIFO_ON] ? RXQ_DEPTH : 1;
        over = rxq_count >= cap;
        if (!over) begin
            rxq_mem[RXQ_IDX_W'((rxq_head + rxq_count) % RXQ_DEPTH)] = ch;
            rxq_count++;
        end
        lsr[LSR_DR] = 1'b1;
        if (over) begin
            lsr[LSR_OE] = 1'b1;
            pend[urm_pkg::PEND_LINE] = 1'b1;
        end
        if (rxq_count >= rx_trigger_level()) begin
            pend[urm_pkg::PEND_RX] = 1'b1;
        end
        tmo_count = 0;
        pend[urm_pkg::PEND_TMO] = 1'b0;
    endfunction

    // In loopback the modem outputs feed the modem inputs, with deltas.
    function automatic void loop_modem();
        logic [7:0] nm;
        logic [7:0] chg;
        logic [7:0] delta;
        nm = '0;
        delta = '0;
        nm[MSR_DSR] = mcr[MCR_DTR];
        nm[MSR_CTS] = mcr[MCR_RTS];
        nm[MSR_RI]  = mcr[MCR_AUX1];
        nm[MSR_DCD] = mcr[MCR_IRQ_GATE];
        chg = (msr ^ nm) & urm_pkg::MSR_STATE_MASK;
        delta[MSR_CTS_DELTA] = chg[MSR_CTS];
        delta[MSR_DSR_DELTA] = chg[MSR_DSR];
        delta[MSR_DCD_DELTA] = chg[MSR_DCD];
        delta[MSR_RI_FALL]   = msr[MSR_RI] & ~nm[MSR_RI];
        msr = nm | delta;
    endfunction

    function automatic logic [7:0] reg_read(input logic [2:0] a);
        logic [7:0] r;
        logic [3:0] code;
        r = '0;
        case (a)
            urm_pkg::ADDR_RBR: begin
                if (lcr[LCR_DIV_LATCH]) begin
                    r = dll;
                end else begin
                    if (rxq_count != 0) begin
                        last_rx = rxq_mem[RXQ_IDX_W'(rxq_head)];
                        rxq_head = (rxq_head + 1) % RXQ_DEPTH;
                        rxq_count--;
                        if (rxq_count == 0) lsr[LSR_DR] = 1'b0;
                        if (rxq_count < rx_trigger_level()) pend[urm_pkg::PEND_RX] = 1'b0;
                        tmo_count = 0;
                        pend[urm_pkg::PEND_TMO] = 1'b0;
                    end
                    r = last_rx;
                end
            end
            urm_pkg::ADDR_IER: r = lcr[LCR_DIV_LATCH] ? dlm : {4'h0, ier};
            urm_pkg::ADDR_IIR: begin
                code = pending_id();
                r = (fcr[FCR_FIFO_ON] ? 8'hC0 : 8'h00) | {4'h0, code};
                if (code == urm_pkg::IIR_THR) pend[urm_pkg::PEND_THR] = 1'b0;
            end
            urm_pkg::ADDR_LCR: r = lcr;
            urm_pkg::ADDR_MCR: r = {3'b000, mcr};
            urm_pkg::ADDR_LSR: begin
                r = lsr;
                lsr = lsr & ~urm_pkg::LSR_READ_CLEAR;
                pend[urm_pkg::PEND_LINE] = 1'b0;
            end
            urm_pkg::ADDR_MSR: begin
                r = msr;
                msr = msr & urm_pkg::MSR_STATE_MASK;
            end
            default: r = spr;
        endcase
        return r;
    endfunction

    function automatic void reg_write(input logic [2:0] a, input logic [7:0] v,
                                      inout urm_pkg::t_rsp rsp);
        logic [3:0] old_ier;
        logic [7:0] old_fcr;
        logic [4:0] old_mcr;
        bit         mode_change;
        case (a)
            urm_pkg::ADDR_RBR: begin
                if (lcr[LCR_DIV_LATCH]) begin
                    dll = v;
                end else begin
                    if (mcr[MCR_LOOP]) begin
                        rx_enqueue(v);
                    end else begin
                        rsp.tx_valid = 1'b1;
                        rsp.tx_data = v;
                    end
                    pend[urm_pkg::PEND_THR] = 1'b1;
                end
            end
            urm_pkg::ADDR_IER: begin
                if (lcr[LCR_DIV_LATCH]) begin
                    dlm = v;
                end else begin
                    old_ier = ier;
                    ier = v[3:0];
                    if (ier[IER_RX] && lsr[LSR_DR]) pend[urm_pkg::PEND_RX] = 1'b1;
                    if (!old_ier[IER_THR] && ier[IER_THR] && lsr[LSR_THRE])
                        pend[urm_pkg::PEND_THR] = 1'b1;
                end
            end
            urm_pkg::ADDR_IIR: begin
                old_fcr = fcr;
                fcr = v & urm_pkg::FCR_KEEP_MASK;
                mode_change = old_fcr[FCR_FIFO_ON] != fcr[FCR_FIFO_ON];
                if (v[FCR_RX_CLEAR] || mode_change || !fcr[FCR_FIFO_ON]) rx_flush();
                if (v[FCR_TX_CLEAR] || mode_change) pend[urm_pkg::PEND_THR] = 1'b1;
            end
            urm_pkg::ADDR_LCR: lcr = v;
            urm_pkg::ADDR_MCR: begin
                old_mcr = mcr;
                mcr = v[4:0];
                if (mcr[MCR_LOOP]) begin
                    loop_modem();
                end else if (old_mcr[MCR_LOOP]) begin
                    msr = '0;
                end
            end
            urm_pkg::ADDR_SPR: spr = v;
            default: ;
        endcase
    endfunction

    // Expected result of one accepted transaction; updates the state.
    function automatic urm_pkg::t_rsp uart_step(input urm_pkg::t_req req);
        urm_pkg::t_rsp rsp;
        rsp = '0;
        case (req.req_type)
            urm_pkg::REQ_READ:  rsp.rdata = reg_read(req.addr);
            urm_pkg::REQ_WRITE: reg_write(req.addr, req.wdata, rsp);
            urm_pkg::REQ_RX:    rx_enqueue(req.wdata);
            default: begin
                if (fcr[FCR_FIFO_ON] && rxq_count != 0 && tmo_count < TMO_TICKS) begin
                    tmo_count++;
                    if (tmo_count >= TMO_TICKS) pend[urm_pkg::PEND_TMO] = 1'b1;
                end
            end
        endcase
        rsp.irq = pending_id() != urm_pkg::IIR_NONE;
        return rsp;
    endfunction

    function automatic void uart_reset_state();
        foreach (rxq_mem[k]) rxq_mem[k] = '0;
        rxq_head = 0;
        rxq_count = 0;
        last_rx = '0;
        ier = '0;
        fcr = '0;
        lcr = '0;
        mcr = '0;
        lsr = urm_pkg::LSR_RESET;
        msr = '0;
        spr = '0;
        dll = '0;
        dlm = '0;
        pend = '0;
        tmo_count = 0;
    endfunction

    function automatic void push_req(input logic [1:0] kind, input logic [2:0] a,
                                     input logic [7:0] d);
        urm_pkg::t_req req;
        req.req_type = kind;
        req.addr = a;
        req.wdata = d;
        req_q.push_back(req);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] rand_addr();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic bit winding_down();
        return req_q.size() < TAIL_ITEMS;
    endfunction

    // Idling is allowed in two of every three windows, and never while winding down.
    function automatic bit idle_window();
        return ((cycle_count / 256) % 3) != 0 && !winding_down();
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("result %0d: %s is %02h, expected %02h", result_count, what, got, want);
        end
    endtask

    // One random scenario: mostly well-formed sequences, some raw noise.
    function automatic void queue_random_scenario();
        int         pick;
        int         n;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            v = rand_byte();
            case ($urandom_range(0, 4))
                0: begin
                    if ($urandom_range(0, 4) != 0) v[MCR_IRQ_GATE] = 1'b1;
                    if ($urandom_range(0, 3) != 0) v[MCR_LOOP] = 1'b0;
                    push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_MCR, v);
                end
                1: push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IER, v);
                2: begin
                    if ($urandom_range(0, 4) != 0) v[FCR_FIFO_ON] = 1'b1;
                    push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IIR, v);
                end
                3: begin
                    v[LCR_DIV_LATCH] = 1'b0;
                    push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LCR, v);
                end
                default: push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_SPR, v);
            endcase
        end else if (pick < 35) begin
            n = $urandom_range(1, 18);
            repeat (n) push_req(urm_pkg::REQ_RX, rand_addr(), rand_byte());
        end else if (pick < 50) begin
            n = $urandom_range(1, 16);
            repeat (n) push_req(urm_pkg::REQ_TICK, rand_addr(), rand_byte());
        end else if (pick < 70) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_IIR, rand_byte());
                end else begin
                    push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_RBR, rand_byte());
                end
            end
        end else if (pick < 78) begin
            case ($urandom_range(0, 2))
                0:       push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_IIR, rand_byte());
                1:       push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_LSR, rand_byte());
                default: push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_MSR, rand_byte());
            endcase
        end else if (pick < 85) begin
            n = $urandom_range(1, 4);
            repeat (n) push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, rand_byte());
        end else if (pick < 90) begin
            // Divisor latch access window.
            v = rand_byte();
            v[LCR_DIV_LATCH] = 1'b1;
            push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LCR, v);
            push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, rand_byte());
            push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IER, rand_byte());
            push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_RBR, rand_byte());
            push_req(urm_pkg::REQ_READ, urm_pkg::ADDR_IER, rand_byte());
            v[LCR_DIV_LATCH] = 1'b0;
            push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LCR, v);
        end else begin
            push_req(2'($urandom_range(0, 3)), rand_addr(), rand_byte());
        end
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle count and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: presents queued requests and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_rsp.push_back(uart_step(i_req));
                accepted_count++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (idle_window() && $urandom_range(0, 15) == 0) begin
                    gap_left = $urandom_range(0, 11);
                    i_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    i_req <= req_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (cycle_count == HOLD_START) begin
            holdoff_left <= HOLD_LEN;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Receiver stall: random bursts plus the hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (holdoff_left != 0) begin
            i_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_window() && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        urm_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected result, rdata", o_rsp.rdata, 8'h00);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.rdata !== want.rdata)
                    report_mismatch("rdata", o_rsp.rdata, want.rdata);
                if (o_rsp.irq !== want.irq)
                    report_mismatch("irq", {7'h0, o_rsp.irq}, {7'h0, want.irq});
                if (o_rsp.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", {7'h0, o_rsp.tx_valid}, {7'h0, want.tx_valid});
                if (o_rsp.tx_data !== want.tx_data)
                    report_mismatch("tx_data", o_rsp.tx_data, want.tx_data);
            end
            result_count++;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int directed;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req = '0;
        cycle_count = 0;
        accepted_count = 0;
        result_count = 0;
        mismatches = 0;
        gap_left = 0;
        stall_left = 0;
        holdoff_left = 0;
        uart_reset_state();

        // Reset values, then THR-empty interrupt and its clearing IIR read.
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_IIR, 8'h00);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_LSR, 8'hFF);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_MCR, 8'h08);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IER, 8'hFF);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_IIR, 8'h00);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, 8'h00);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, 8'hFF);
        // FIFO mode with the highest trigger level, one byte and a tick, then a read and an empty read.
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IIR, 8'hC7);
        push_req(urm_pkg::REQ_RX,    urm_pkg::ADDR_RBR, 8'hA5);
        push_req(urm_pkg::REQ_TICK,  urm_pkg::ADDR_SPR, 8'hFF);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_RBR, 8'h00);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_RBR, 8'h00);
        // Single-byte mode overrun and the LSR read that clears it.
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IIR, 8'h00);
        push_req(urm_pkg::REQ_RX,    urm_pkg::ADDR_RBR, 8'h11);
        push_req(urm_pkg::REQ_RX,    urm_pkg::ADDR_RBR, 8'h22);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_LSR, 8'h00);
        // Divisor latch.
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LCR, 8'h80);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, 8'hFF);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_IER, 8'h01);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_RBR, 8'h00);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_IER, 8'h00);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LCR, 8'h03);
        // Loopback: modem status, THR byte looped into the receiver, exit.
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_MCR, 8'h1F);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_MSR, 8'h00);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_RBR, 8'h3C);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_RBR, 8'h00);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_MCR, 8'h00);
        // Writes to the read-only offsets are ignored; scratch round trip.
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_LSR, 8'hFF);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_MSR, 8'hFF);
        push_req(urm_pkg::REQ_WRITE, urm_pkg::ADDR_SPR, 8'hFF);
        push_req(urm_pkg::REQ_READ,  urm_pkg::ADDR_SPR, 8'h00);

        directed = req_q.size();
        while (req_q.size() < directed + RANDOM_ITEMS) queue_random_scenario();
        total_items = req_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_rsp.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
